// ===== sv/bvl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Bezier velocity / acceleration limit penalty block.
// No dependencies; used by bvl_ctrl, bvl_dp and the top level.
package bvl_pkg;

    // Field and register widths
    localparam int PT_W     = 32;
    localparam int GRAD_W   = 48;
    localparam int COST_W   = 48;
    localparam int SCALE_W  = 24;
    localparam int LIM_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int MAG_W  = 34;            // magnitude of a second difference
    localparam int MA_W   = 36;            // multiplier operand A
    localparam int MB_W   = 25;            // multiplier operand B
    localparam int PROD_W = MA_W + MB_W;
    localparam int E_W    = 50;            // excess over the limit
    localparam int SQ_W   = 36;            // widest excess that is squared exactly
    localparam int SQ_H   = 18;            // split point of the square
    localparam int G_H    = 25;            // split point of excess times scale
    localparam int ACC_W  = 76;
    localparam int G_W    = 51;            // gradient sums before saturation

    localparam logic [COST_W-1:0]        COST_MAX = '1;
    localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

    localparam logic [1:0] PH_EMPTY  = 2'd0;
    localparam logic [1:0] PH_ONE    = 2'd1;
    localparam logic [1:0] PH_FULL   = 2'd3;
    localparam logic [1:0] SLOT_LAST = 2'd3;
    localparam logic [1:0] AX_LAST   = 2'd2;

    typedef enum logic [1:0] {
        CFG_VEL_LIMIT = 2'd0,
        CFG_ACC_LIMIT = 2'd1,
        CFG_VEL_SCALE = 2'd2,
        CFG_ACC_SCALE = 2'd3
    } t_cfg_idx;

    // Limit checks of one axis: three velocity, two acceleration
    typedef enum logic [2:0] {
        CHK_V01  = 3'd0,
        CHK_V12  = 3'd1,
        CHK_V23  = 3'd2,
        CHK_A012 = 3'd3,
        CHK_A123 = 3'd4
    } t_chk;

    typedef enum logic [1:0] {LD_NONE, LD_START, LD_STORE, LD_SEG} t_ld;
    typedef enum logic [2:0] {MS_V, MS_SQ_LO, MS_SQ_HI, MS_G_LO, MS_G_HI} t_msel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_SQ, ACC_ADD_G} t_aop;
    typedef enum logic [1:0] {CF_ZERO, CF_POS, CF_NEG, CF_NEG2} t_coef;

    typedef struct packed {
        t_ld        ld;
        logic [1:0] slot;
        t_chk       chk;
        logic [1:0] ax;
        logic       diff;
        logic       mul_en;
        t_msel      msel;
        t_aop       aop;
        logic       vcmp;
        logic       cost;
        logic       grad;
        logic       rot;
        logic       shift;
        logic [1:0] oslot;
    } t_cmd;

    typedef struct packed {
        logic pen;
    } t_sts;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
        logic                   track_start;
    } t_pt_req;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_z;
        logic [1:0]               point_slot;
        logic [COST_W-1:0]        running_cost;
        logic                     segment_done;
    } t_grad_req;

    // How a limit check's gradient term lands on each control point
    function automatic t_coef coef(input t_chk chk, input logic [1:0] slot);
        t_coef c;
        c = CF_ZERO;
        unique case (chk)
            CHK_V01: begin
                if (slot == 2'd1) c = CF_POS;
                else if (slot == 2'd0) c = CF_NEG;
            end
            CHK_V12: begin
                if (slot == 2'd2) c = CF_POS;
                else if (slot == 2'd1) c = CF_NEG;
            end
            CHK_V23: begin
                if (slot == 2'd3) c = CF_POS;
                else if (slot == 2'd2) c = CF_NEG;
            end
            CHK_A012: begin
                if (slot == 2'd0 || slot == 2'd2) c = CF_POS;
                else if (slot == 2'd1) c = CF_NEG2;
            end
            CHK_A123: begin
                if (slot == 2'd1 || slot == 2'd3) c = CF_POS;
                else if (slot == 2'd2) c = CF_NEG2;
            end
            default: c = CF_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/bvl_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one request of type T.
// No dependencies.
interface bvl_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/bvl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the limit penalty block: point phase, check sequencing, result slots.
// Depends on bvl_pkg.
module bvl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_start,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  bvl_pkg::t_sts i_sts,
    output bvl_pkg::t_cmd o_cmd
);
    import bvl_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DIFF  = 12'b0000_0000_0010,
        S_VMUL  = 12'b0000_0000_0100,
        S_VCMP  = 12'b0000_0000_1000,
        S_SQLO  = 12'b0000_0001_0000,
        S_SQHI  = 12'b0000_0010_0000,
        S_SQADD = 12'b0000_0100_0000,
        S_COST  = 12'b0000_1000_0000,
        S_GHI   = 12'b0001_0000_0000,
        S_GADD  = 12'b0010_0000_0000,
        S_GRAD  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_phase, n_phase;
    t_chk       r_chk, n_chk;
    logic [1:0] r_ax, n_ax;
    logic [1:0] r_k, n_k;
    logic       in_acc, out_acc, adv;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_chk   = r_chk;
        n_ax    = r_ax;
        n_k     = r_k;
        adv     = 1'b0;
        o_cmd       = '0;
        o_cmd.chk   = r_chk;
        o_cmd.ax    = r_ax;
        o_cmd.oslot = r_k;
        o_cmd.slot  = r_phase;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        in_acc  = i_in_valid && o_in_ready;
        out_acc = o_out_valid && i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_start || r_phase == PH_EMPTY) begin
                        o_cmd.ld = LD_START;
                        n_phase  = PH_ONE;
                    end else if (r_phase != PH_FULL) begin
                        o_cmd.ld = LD_STORE;
                        n_phase  = r_phase + 2'd1;
                    end else begin
                        o_cmd.ld = LD_SEG;
                        n_chk    = CHK_V01;
                        n_ax     = 2'd0;
                        n_state  = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_V;
                n_state      = S_VCMP;
            end
            S_VCMP: begin
                o_cmd.vcmp = 1'b1;
                if (i_sts.pen) n_state = S_SQLO;
                else adv = 1'b1;
            end
            S_SQLO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_SQ_LO;
                n_state      = S_SQHI;
            end
            S_SQHI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_SQ_HI;
                o_cmd.aop    = ACC_LOAD;
                n_state      = S_SQADD;
            end
            S_SQADD: begin
                o_cmd.aop = ACC_ADD_SQ;
                n_state   = S_COST;
            end
            S_COST: begin
                o_cmd.cost   = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_G_LO;
                n_state      = S_GHI;
            end
            S_GHI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_G_HI;
                o_cmd.aop    = ACC_LOAD;
                n_state      = S_GADD;
            end
            S_GADD: begin
                o_cmd.aop = ACC_ADD_G;
                n_state   = S_GRAD;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                adv        = 1'b1;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_k = r_k + 2'd1;
                    if (r_k == SLOT_LAST) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Step to the next check, axis or the result phase
        if (adv) begin
            if (r_chk == CHK_A123) begin
                o_cmd.rot = 1'b1;
                n_chk     = CHK_V01;
                if (r_ax == AX_LAST) begin
                    o_cmd.shift = 1'b1;
                    n_phase     = PH_ONE;
                    n_k         = 2'd0;
                    n_state     = S_OUT;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_DIFF;
                end
            end else begin
                n_chk   = t_chk'(r_chk + 3'd1);
                n_state = S_DIFF;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_EMPTY;
            r_chk   <= CHK_V01;
            r_ax    <= 2'd0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_chk   <= n_chk;
            r_ax    <= n_ax;
            r_k     <= n_k;
        end
    end

    // A segment's closing point starts the check sequence
    a_seg_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_FULL && !i_start) |=> (r_state == S_DIFF))
        else $error("segment point did not start the checks");

    // Last result returns to idle with the end point held as point 0
    a_seg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_k == SLOT_LAST) |=> (r_state == S_IDLE && r_phase == PH_ONE))
        else $error("segment did not close correctly");

    // Axis counter stays on the three axes
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ax <= AX_LAST)
        else $error("axis counter out of range");

    // A check within limit moves straight on to the next one
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VCMP && !i_sts.pen && r_chk != CHK_A123) |=> (r_state == S_DIFF))
        else $error("unpenalised check did not advance");

endmodule

// ===== sv/bvl_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the limit penalty block: config registers, point window, shared
// multiplier with accumulator, cost and gradient registers. Depends on bvl_pkg.
module bvl_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bvl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bvl_pkg::CFG_W-1:0]       i_cfg_data,
    input  bvl_pkg::t_pt_req                i_pt,
    input  bvl_pkg::t_cmd                   i_cmd,
    output bvl_pkg::t_sts                   o_sts,
    output bvl_pkg::t_grad_req              o_res
);
    import bvl_pkg::*;

    localparam logic [ACC_W:0] HALF = {{ACC_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [LIM_W-1:0]     r_vel_limit, r_acc_limit;
    logic [SCALE_W-1:0]   r_vel_scale, r_acc_scale;
    logic [3*PT_W-1:0]    r_win [4];
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic [PROD_W-1:0]    r_prod;
    logic [ACC_W-1:0]     r_acc;
    logic [E_W-1:0]       r_e;
    logic [COST_W-1:0]    r_cost;
    logic signed [G_W-1:0] r_g [4][3];

    logic [3*PT_W-1:0]     pt_w;
    logic signed [PT_W-1:0] p [4];
    logic signed [MAG_W:0] dv [3];
    logic signed [MAG_W:0] da [2];
    logic signed [MAG_W:0] d_sel;
    logic                  is_acc;
    logic [SCALE_W-1:0]    scale;
    logic [LIM_W-1:0]      limit;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [PROD_W:0]       v_sum, v, lim_ext;
    logic                  pen;
    logic [ACC_W:0]        sq_sum, sq_r, g_sum, g_r;
    logic [COST_W-1:0]     sq;
    logic [COST_W:0]       c_sum;
    logic [GRAD_W-1:0]     m;
    logic signed [GRAD_W-1:0] t_term;
    logic signed [G_W-1:0] t_ext;

    function automatic logic [3*PT_W-1:0] rot_ax(input logic [3*PT_W-1:0] w);
        return {w[PT_W-1:0], w[3*PT_W-1:PT_W]};
    endfunction

    function automatic logic signed [GRAD_W-1:0] sat_g(input logic signed [G_W-1:0] x);
        logic signed [GRAD_W-1:0] r;
        if (x > G_W'(GRAD_MAX)) r = GRAD_MAX;
        else if (x < G_W'(GRAD_MIN)) r = GRAD_MIN;
        else r = x[GRAD_W-1:0];
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_limit <= '0;
            r_acc_limit <= '0;
            r_vel_scale <= '0;
            r_acc_scale <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VEL_LIMIT: r_vel_limit <= i_cfg_data;
                CFG_ACC_LIMIT: r_acc_limit <= i_cfg_data;
                CFG_VEL_SCALE: r_vel_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_ACC_SCALE: r_acc_scale <= i_cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // Point window; the axis under check always sits in the low word
    assign pt_w = {i_pt.point_z, i_pt.point_y, i_pt.point_x};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.ld)
            LD_START: r_win[0] <= pt_w;
            LD_STORE: r_win[i_cmd.slot] <= pt_w;
            LD_SEG:   r_win[SLOT_LAST] <= pt_w;
            LD_NONE: begin
                // rotate to the next axis; on shift the end point becomes point 0
                if (i_cmd.rot) begin
                    for (int k = 1; k < 4; k++) r_win[k] <= rot_ax(r_win[k]);
                    r_win[0] <= i_cmd.shift ? rot_ax(r_win[SLOT_LAST]) : rot_ax(r_win[0]);
                end
            end
        endcase
    end

    // First and second differences of the current axis
    always_comb begin
        for (int k = 0; k < 4; k++) p[k] = $signed(r_win[k][PT_W-1:0]);
        for (int i = 0; i < 3; i++) dv[i] = (MAG_W+1)'(p[i+1]) - (MAG_W+1)'(p[i]);
        for (int i = 0; i < 2; i++)
            da[i] = (MAG_W+1)'(p[i+2]) - (MAG_W+1)'(p[i+1]) - (MAG_W+1)'(p[i+1])
                  + (MAG_W+1)'(p[i]);
        unique case (i_cmd.chk)
            CHK_V01:  d_sel = dv[0];
            CHK_V12:  d_sel = dv[1];
            CHK_V23:  d_sel = dv[2];
            CHK_A012: d_sel = da[0];
            CHK_A123: d_sel = da[1];
            default:  d_sel = '0;
        endcase
        is_acc = (i_cmd.chk == CHK_A012) || (i_cmd.chk == CHK_A123);
        scale  = is_acc ? r_acc_scale : r_vel_scale;
        limit  = is_acc ? r_acc_limit : r_vel_limit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_neg <= d_sel[MAG_W];
            r_mag <= d_sel[MAG_W] ? MAG_W'(-d_sel) : d_sel[MAG_W-1:0];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (i_cmd.msel)
            MS_V: begin
                mul_a = MA_W'(r_mag);
                mul_b = MB_W'(scale);
            end
            MS_SQ_LO: begin
                mul_a = r_e[SQ_W-1:0];
                mul_b = MB_W'(r_e[SQ_H-1:0]);
            end
            MS_SQ_HI: begin
                mul_a = r_e[SQ_W-1:0];
                mul_b = MB_W'(r_e[SQ_W-1:SQ_H]);
            end
            MS_G_LO: begin
                mul_a = MA_W'(scale);
                mul_b = r_e[G_H-1:0];
            end
            MS_G_HI: begin
                mul_a = MA_W'(scale);
                mul_b = r_e[E_W-1:G_H];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register and partial product accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        unique case (i_cmd.aop)
            ACC_HOLD:   r_acc <= r_acc;
            ACC_LOAD:   r_acc <= ACC_W'(r_prod);
            ACC_ADD_SQ: r_acc <= r_acc + (ACC_W'(r_prod) << SQ_H);
            ACC_ADD_G:  r_acc <= r_acc + (ACC_W'(r_prod) << G_H);
        endcase
    end

    // Rounded scaled magnitude against the limit
    always_comb begin
        v_sum   = {1'b0, r_prod} + HALF[PROD_W:0];
        v       = v_sum >> FRAC_BITS;
        lim_ext = (PROD_W+1)'(limit);
        pen     = v > lim_ext;
    end
    assign o_sts.pen = pen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vcmp) r_e <= E_W'(v - lim_ext);
    end

    // Squared excess into the saturating cost
    always_comb begin
        sq_sum = {1'b0, r_acc} + HALF;
        sq_r   = sq_sum >> FRAC_BITS;
        if ((|r_e[E_W-1:SQ_W]) || (sq_r > (ACC_W+1)'(COST_MAX))) sq = COST_MAX;
        else sq = sq_r[COST_W-1:0];
        c_sum = {1'b0, r_cost} + {1'b0, sq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost <= '0;
        end else if (i_cmd.ld == LD_START) begin
            r_cost <= '0;
        end else if (i_cmd.cost) begin
            r_cost <= c_sum[COST_W] ? COST_MAX : c_sum[COST_W-1:0];
        end
    end

    // Gradient term, twice the excess times the scale
    always_comb begin
        g_sum  = {r_acc, 1'b0} + HALF;
        g_r    = g_sum >> FRAC_BITS;
        m      = (g_r > (ACC_W+1)'(GRAD_MAX)) ? GRAD_MAX : g_r[GRAD_W-1:0];
        t_term = r_neg ? -$signed(m) : $signed(m);
        t_ext  = G_W'(t_term);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
                if (i_cmd.ld == LD_SEG) begin
                    r_g[k][a] <= '0;
                end else if (i_cmd.grad && 2'(a) == i_cmd.ax) begin
                    unique case (coef(i_cmd.chk, 2'(k)))
                        CF_ZERO: r_g[k][a] <= r_g[k][a];
                        CF_POS:  r_g[k][a] <= r_g[k][a] + t_ext;
                        CF_NEG:  r_g[k][a] <= r_g[k][a] - t_ext;
                        CF_NEG2: r_g[k][a] <= r_g[k][a] - (t_ext <<< 1);
                    endcase
                end
            end
        end
    end

    // Result fields for the slot being delivered
    always_comb begin
        o_res.grad_x       = sat_g(r_g[i_cmd.oslot][0]);
        o_res.grad_y       = sat_g(r_g[i_cmd.oslot][1]);
        o_res.grad_z       = sat_g(r_g[i_cmd.oslot][2]);
        o_res.point_slot   = i_cmd.oslot;
        o_res.running_cost = r_cost;
        o_res.segment_done = (i_cmd.oslot == SLOT_LAST);
    end

    // Cost only grows within a track
    a_cost_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld != LD_START) |=> (r_cost >= $past(r_cost)))
        else $error("running cost decreased within a track");

endmodule

// ===== sv/bezier_vel_acc_limit_penalty.sv =====
`timescale 1ns / 1ps
// Top level of the Bezier velocity / acceleration limit penalty block.
// Depends on bvl_pkg, bvl_stream_if, bvl_ctrl and bvl_dp.
//
//  channel  | dir | payload                                   | handshake
//  i_pt     | in  | point_x/y/z, track_start                  | valid/ready
//  o_grad   | out | grad_x/y/z, point_slot, running_cost,     | valid/ready
//           |     | segment_done                              |
//  i_cfg_*  | in  | register index, data                      | write enable
//
// A point that only fills the window is stored. A segment's closing point runs
// 15 limit checks on one shared 36x25 multiplier; a check over its limit also
// squares the excess into the cost and adds gradient terms. Then come four
// results, one per cycle while o_grad.ready is high. No point is taken while
// checks run or results wait. Reset is synchronous; the first point after
// reset opens a track.
module bezier_vel_acc_limit_penalty #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bvl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bvl_pkg::CFG_W-1:0]     i_cfg_data,
    bvl_stream_if.sink                    i_pt,
    bvl_stream_if.source                  o_grad
);
    import bvl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    bvl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .i_start     (i_pt.data.track_start),
        .o_out_valid (o_grad.valid),
        .i_out_ready (o_grad.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage
    bvl_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (i_pt.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_grad.data)
    );

endmodule
